[rtl/core/tksh_pkg.sv]
// Shared types and constants for the top-k running sum heap.
package tksh_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int VAL_W    = 32;
  localparam int KEEP_W   = 11;
  localparam int SUM_W    = 43;
  localparam int TOT_W    = 42;
  localparam int OCNT_W   = 11;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_ROOT_RD,
    S_ROOT_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP
  } state_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] data;
  } mem_wr_t;

endpackage

[rtl/core/tksh_mem.sv]
// Heap storage with one write port and one registered read port.
module tksh_mem
  import tksh_pkg::*;
(
  input  logic             clk,
  input  mem_wr_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/top_k_running_sum_heap.sv]
// Top level: sequencer and compare unit that keep the k largest values and their sum.
// A report item is taken while idle and strobes its result in the next cycle; results cannot stall.
// An insert below the limit holds busy in a read and a compare state per parent compared, plus a
// read at the root. At the limit it reads and compares the root, then reads both children and
// compares per node, with a lone read at a final leaf, since the one read port serializes reads.
// Reset (rst_n low, synchronous) empties the heap, clears the sum and sets keep_count to 1.
module top_k_running_sum_heap
  import tksh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_action,
  input  logic signed [VAL_W-1:0] in_value,
  output logic              out_valid,
  output logic signed [TOT_W-1:0] out_total,
  output logic [OCNT_W-1:0] out_entry_count,
  input  logic              cfg_we,
  input  logic [KEEP_W-1:0] cfg_data
);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic signed [VAL_W-1:0] cur_r, cur_nxt;
  logic signed [VAL_W-1:0] lval_r, lval_nxt;
  logic [CNT_W-1:0]        size_r, size_nxt;
  logic [SUM_W-1:0]        total_r, total_nxt;
  logic [KEEP_W-1:0]       keep_r;
  logic                    out_valid_r;
  logic [TOT_W-1:0]        out_total_r;
  logic [OCNT_W-1:0]       out_count_r;

  mem_wr_t          wr;
  logic [IDX_W-1:0] rd_addr;
  logic [VAL_W-1:0] rd_data;
  logic signed [VAL_W-1:0] rd_val;

  logic [CNT_W-1:0]  keff;
  logic              accept;
  logic [IDX_W-1:0]  parent;
  logic [IDX_W+1:0]  l_ext, r_ext, size_ext;
  logic              r_ok;
  logic              l_lt, r_lt;
  logic signed [VAL_W-1:0] min1, child_val;
  logic [IDX_W-1:0]  best;

  tksh_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_val   = $signed(rd_data);
  assign accept   = start && (state_r == S_IDLE);
  assign keff     = (keep_r > KEEP_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(keep_r);
  assign parent   = (pos_r - IDX_W'(1)) >> 1;
  assign l_ext    = {1'b0, pos_r, 1'b1};
  assign r_ext    = l_ext + (IDX_W+2)'(1);
  assign size_ext = {1'b0, size_r};
  assign r_ok     = r_ext < size_ext;
  assign l_lt     = lval_r < cur_r;
  assign min1     = l_lt ? lval_r : cur_r;
  assign r_lt     = r_ok && (rd_val < min1);
  assign child_val = r_lt ? rd_val : lval_r;
  assign best     = r_lt ? r_ext[IDX_W-1:0] : (l_lt ? l_ext[IDX_W-1:0] : pos_r);

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cur_nxt   = cur_r;
    lval_nxt  = lval_r;
    size_nxt  = size_r;
    total_nxt = total_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_action == ACT_INSERT) begin
          cur_nxt = in_value;
          if (size_r < keff) begin
            pos_nxt   = size_r[IDX_W-1:0];
            size_nxt  = size_r + CNT_W'(1);
            total_nxt = total_r + {{(SUM_W-VAL_W){in_value[VAL_W-1]}}, in_value};
            state_nxt = S_UP_RD;
          end else if (size_r != '0) begin
            state_nxt = S_ROOT_RD;
          end
        end
      end
      S_UP_RD: begin
        state_nxt = (pos_r == '0) ? S_IDLE : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (rd_val <= cur_r) begin
          state_nxt = S_IDLE;
        end else begin
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end
      end
      S_ROOT_RD: begin
        state_nxt = S_ROOT_CMP;
      end
      S_ROOT_CMP: begin
        if (cur_r > rd_val) begin
          total_nxt = total_r + {{(SUM_W-VAL_W){cur_r[VAL_W-1]}}, cur_r}
                      - {{(SUM_W-VAL_W){rd_val[VAL_W-1]}}, rd_val};
          pos_nxt   = '0;
          state_nxt = S_DN_RDL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DN_RDL: begin
        state_nxt = (l_ext < size_ext) ? S_DN_RDR : S_IDLE;
      end
      S_DN_RDR: begin
        lval_nxt  = rd_val;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (best == pos_r) begin
          state_nxt = S_IDLE;
        end else begin
          pos_nxt   = best;
          state_nxt = S_DN_RDL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = '0;
    wr.en   = 1'b0;
    wr.addr = pos_r;
    wr.data = cur_r;
    unique case (state_r)
      S_UP_RD: begin
        rd_addr = parent;
        wr.en   = (pos_r == '0);
      end
      S_UP_CMP: begin
        wr.en = 1'b1;
        if (rd_val > cur_r) begin
          wr.data = rd_val;
        end
      end
      S_DN_RDL: begin
        rd_addr = l_ext[IDX_W-1:0];
        wr.en   = !(l_ext < size_ext);
      end
      S_DN_RDR: begin
        rd_addr = r_ext[IDX_W-1:0];
      end
      S_DN_CMP: begin
        wr.en = 1'b1;
        if (best != pos_r) begin
          wr.data = child_val;
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      total_r     <= '0;
      keep_r      <= KEEP_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      total_r     <= total_nxt;
      out_valid_r <= accept && (in_action == ACT_REPORT);
      if (cfg_we) begin
        keep_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    cur_r  <= cur_nxt;
    lval_r <= lval_nxt;
    if (accept && in_action == ACT_REPORT) begin
      out_total_r <= (size_r == '0) ? '0 : total_r[TOT_W-1:0];
      out_count_r <= OCNT_W'(size_r);
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_total       = $signed(out_total_r);
  assign out_entry_count = out_count_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= CNT_W'(CAPACITY))
    else $error("Heap size exceeds capacity.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_action == ACT_REPORT))
    else $error("Result strobe without a report item.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (size_r != $past(size_r)) |-> ($past(state_r) == S_IDLE &&
                                   size_r == $past(size_r) + CNT_W'(1)))
    else $error("Heap size changed outside of an accepted insert.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DN_CMP) |-> ($past(state_r) == S_DN_RDR))
    else $error("Child compare entered without reading both children.");

endmodule

[tb/top_k_running_sum_heap_tb.sv]
// Self-checking testbench for the top-k running sum heap with its own heap predictor.
module top_k_running_sum_heap_tb
  import tksh_pkg::*;
();

  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic signed [TOT_W-1:0] total;
    logic [OCNT_W-1:0]       entry_count;
  } report_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic                    in_action;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic signed [TOT_W-1:0] out_total;
  logic [OCNT_W-1:0]       out_entry_count;
  logic                    cfg_we;
  logic [KEEP_W-1:0]       cfg_data;

  logic signed [VAL_W-1:0] kept_vals [CAPACITY];
  int                      held;
  logic signed [SUM_W-1:0] kept_sum;
  logic [KEEP_W-1:0]       keep_limit;
  report_t                 pending_reports[$];
  int                      idle_pct;
  int                      error_count;

  top_k_running_sum_heap dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_total      (out_total),
    .out_entry_count(out_entry_count),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void heap_insert(logic signed [VAL_W-1:0] val);
    int pos;
    int up;
    int best;
    int kid;
    int limit;
    logic signed [VAL_W-1:0] swap;
    limit = (keep_limit > CAPACITY) ? CAPACITY : int'(keep_limit);
    if (held < limit) begin
      kept_vals[held] = val;
      pos = held;
      held++;
      kept_sum = kept_sum + val;
      while (pos != 0) begin
        up = (pos - 1) / 2;
        if (kept_vals[up] <= kept_vals[pos]) break;
        swap = kept_vals[up];
        kept_vals[up] = kept_vals[pos];
        kept_vals[pos] = swap;
        pos = up;
      end
    end else if (held != 0 && val > kept_vals[0]) begin
      kept_sum = kept_sum + val - kept_vals[0];
      kept_vals[0] = val;
      pos = 0;
      forever begin
        best = pos;
        kid = 2 * pos + 1;
        if (kid < held && kept_vals[kid] < kept_vals[best]) best = kid;
        if (kid + 1 < held && kept_vals[kid + 1] < kept_vals[best]) best = kid + 1;
        if (best == pos) break;
        swap = kept_vals[best];
        kept_vals[best] = kept_vals[pos];
        kept_vals[pos] = swap;
        pos = best;
      end
    end
  endfunction

  function automatic void predict_item(logic act, logic signed [VAL_W-1:0] val);
    report_t rep;
    if (act == ACT_REPORT) begin
      rep.total = (held == 0) ? '0 : kept_sum[TOT_W-1:0];
      rep.entry_count = OCNT_W'(held);
      pending_reports.insert(pending_reports.size(), rep);
    end else begin
      heap_insert(val);
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1, 2: return VAL_W'($signed($urandom_range(8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic act, input logic signed [VAL_W-1:0] val);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct)
      gap = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(3, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(act, val);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (busy || pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] keep);
    cfg_we <= 1'b1;
    cfg_data <= keep;
    @(posedge clk);
    cfg_we <= 1'b0;
    keep_limit = keep;
  endtask

  task automatic run_random(input logic [KEEP_W-1:0] keep, input int count,
                            input int idle, input int insert_pct);
    settle();
    write_keep(keep);
    idle_pct = idle;
    repeat (count) begin
      if ($urandom_range(99) < insert_pct)
        send_item(ACT_INSERT, pick_value());
      else
        send_item(ACT_REPORT, $urandom);
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result total=%0d entry_count=%0d",
                 $time, out_total, out_entry_count);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_total !== want.total) begin
          $display("%0t: total expected %0d actual %0d", $time, want.total, out_total);
          error_count++;
        end
        if (out_entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, want.entry_count, out_entry_count);
          error_count++;
        end
      end
    end
  end

  task automatic test_reset_keep_one();
    send_item(ACT_REPORT, 32'sh0);
    send_item(ACT_INSERT, 32'sh7FFF_FFFF);
    send_item(ACT_REPORT, 32'sh0);
    send_item(ACT_INSERT, 32'sh8000_0000);
    send_item(ACT_INSERT, 32'sh7FFF_FFFF);
    send_item(ACT_REPORT, 32'shFFFF_FFFF);
  endtask

  task automatic test_keep_zero();
    settle();
    write_keep('0);
    send_item(ACT_INSERT, -32'sd5);
    send_item(ACT_INSERT, 32'sh7FFF_FFFF);
    send_item(ACT_REPORT, 32'sh0);
  endtask

  task automatic test_three_largest();
    settle();
    write_keep(KEEP_W'(3));
    send_item(ACT_INSERT, 32'sh8000_0000);
    send_item(ACT_INSERT, 32'sh0);
    send_item(ACT_INSERT, -32'sd1);
    send_item(ACT_INSERT, 32'sh8000_0000);
    send_item(ACT_REPORT, 32'sh0);
    send_item(ACT_INSERT, 32'sd1);
    send_item(ACT_REPORT, 32'sh0);
  endtask

  task automatic test_small_keep();
    run_random(KEEP_W'(5), 100, 0, 75);
  endtask

  task automatic test_fill_past_capacity();
    run_random('1, 1150, 45, 92);
  endtask

  task automatic test_keep_at_capacity();
    run_random(KEEP_W'(CAPACITY), 50, 0, 75);
  endtask

  task automatic test_keep_below_size();
    run_random(KEEP_W'(7), 150, 16, 75);
  endtask

  task automatic test_keep_zero_random();
    run_random('0, 100, 45, 75);
  endtask

  task automatic test_random_keep();
    run_random(KEEP_W'($urandom_range(2047)), 100, 16, 75);
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_action <= ACT_INSERT;
    in_value <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    held = 0;
    kept_sum = '0;
    keep_limit = KEEP_W'(1);
    idle_pct = 0;
    error_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_keep_one();
    test_keep_zero();
    test_three_largest();
    test_small_keep();
    test_fill_past_capacity();
    test_keep_at_capacity();
    test_keep_below_size();
    test_keep_zero_random();
    test_random_keep();
    settle();
    if (error_count == 0 && pending_reports.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
rtl/core/tksh_pkg.sv
rtl/core/tksh_mem.sv
rtl/core/top_k_running_sum_heap.sv
tb/top_k_running_sum_heap_tb.sv
